/* hdl/householder_qr_decomposer_macros.svh */
// ----------------------------------------------------------------------------
// householder_qr_decomposer_macros
// Assertion macros shared by the QR decomposer RTL.
// ----------------------------------------------------------------------------
`ifndef HOUSEHOLDER_QR_DECOMPOSER_MACROS_SVH
`define HOUSEHOLDER_QR_DECOMPOSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HQR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HQR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hqr_pkg.sv */
// ----------------------------------------------------------------------------
// hqr_pkg
// Types, constants and helpers for the Householder QR decomposer.
// ----------------------------------------------------------------------------
package hqr_pkg;

    localparam int MAX_SIZE    = 4;
    localparam int IDX_W       = 2;
    localparam int DATA_W      = 32;
    localparam int SIZE_W      = 3;
    localparam int MAT_ADDR_W  = 1 + 2 * IDX_W;
    localparam int MAT_DEPTH   = 2 ** MAT_ADDR_W;
    localparam int SQRT_STEPS  = 24;
    localparam int DIV_STEPS   = 64;
    localparam int ACC_W       = 51;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic
    {
        MAT_QT = 1'b0,
        MAT_R  = 1'b1
    } mat_t;

    typedef struct packed
    {
        idx_t                     row_index;
        idx_t                     column_index;
        logic signed [DATA_W-1:0] element_value;
        logic                     is_last;
    } hqr_in_t;

    typedef struct packed
    {
        logic                     which_matrix;
        idx_t                     out_row;
        idx_t                     out_column;
        logic signed [DATA_W-1:0] out_value;
        logic                     last_result;
    } hqr_out_t;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_QINIT,
        S_NRD,
        S_NMUL,
        S_NACC,
        S_SQRT,
        S_AMUL,
        S_AADD,
        S_HROW,
        S_HMUL,
        S_HLD,
        S_HDIV,
        S_HWR,
        S_PRD,
        S_PMUL,
        S_PACC,
        S_PWR,
        S_CRD,
        S_CWR,
        S_ERD,
        S_ELD
    } hqr_state_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/householder_qr_decomposer.sv */
// Sequence: while idle, elements are stored into R; after the last element, Q^T is
// set to the identity, then each column i = 0..n-2 is reduced (skipped if its norm is
// zero or the divisor a is not positive), each reflector entry formed by the 64-step
// serial divider; then the results are emitted, Q^T first and then R.
// Throughput: one matrix at a time; new elements are taken only when idle.
// Reset: rst_n clears control state and sets matrix_size to 4.
// ----------------------------------------------------------------------------
// householder_qr_decomposer
// Householder QR of a square Q15.16 matrix held in two synchronous RAMs.
// ----------------------------------------------------------------------------
`include "householder_qr_decomposer_macros.svh"

module householder_qr_decomposer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [hqr_pkg::SIZE_W-1:0] cfg_write_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  hqr_pkg::hqr_in_t         in_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output hqr_pkg::hqr_out_t        out_item
);

    import hqr_pkg::*;

    // ------------------------------------------------------------------
    // Storage
    // Matrix RAM: address {mat, row, col}; Q^T in the lower half, R upper.
    // Scratch RAM: reflector H in the lower half, product work area upper.
    // ------------------------------------------------------------------
    logic                  ma_we;
    logic [MAT_ADDR_W-1:0] ma_waddr, ma_raddr;
    logic [DATA_W-1:0]     ma_wdata, ma_rdata;
    logic                  mb_we;
    logic [MAT_ADDR_W-1:0] mb_waddr, mb_raddr;
    logic [DATA_W-1:0]     mb_wdata, mb_rdata;

    hqr_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (ma_we),
        .waddr (ma_waddr),
        .wdata (ma_wdata),
        .raddr (ma_raddr),
        .rdata (ma_rdata)
    );

    hqr_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_scratch_ram (
        .clk   (clk),
        .we    (mb_we),
        .waddr (mb_waddr),
        .wdata (mb_wdata),
        .raddr (mb_raddr),
        .rdata (mb_rdata)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    hqr_state_t               state_reg, state_next;
    logic [SIZE_W-1:0]        size_reg;
    logic [SIZE_W-1:0]        n_reg, n_next;
    idx_t                     i_reg, i_next;
    idx_t                     j_reg, j_next;
    idx_t                     k_reg, k_next;
    idx_t                     m_reg, m_next;
    mat_t                     tgt_reg, tgt_next;
    logic [30:0]              sig2_reg, sig2_next;
    logic signed [DATA_W-1:0] rii_reg, rii_next;
    logic signed [DATA_W-1:0] u_reg [MAX_SIZE];
    logic signed [DATA_W-1:0] u_next [MAX_SIZE];
    logic signed [DATA_W-1:0] uk_reg, uk_next;
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [47:0]              sv_reg, sv_next;
    logic [23:0]              root_reg, root_next;
    logic [25:0]              srem_reg, srem_next;
    logic [4:0]               scnt_reg, scnt_next;
    logic [63:0]              dq_reg, dq_next;
    logic [32:0]              drem_reg, drem_next;
    logic [5:0]               dcnt_reg, dcnt_next;
    logic                     dneg_reg, dneg_next;
    logic                     out_valid_reg, out_valid_next;
    hqr_out_t                 out_item_reg, out_item_next;

    // ------------------------------------------------------------------
    // Shared datapath terms
    // ------------------------------------------------------------------
    logic                     in_acc;
    logic                     out_free;
    logic [SIZE_W-1:0]        n_minus;
    idx_t                     last_idx, col_end;
    logic                     j_last, k_last, m_last, col_last;
    logic signed [63:0]       prod_sh;
    logic [48:0]              sig2_sum;
    logic [30:0]              sig2_upd;
    logic signed [DATA_W-1:0] sig;
    logic signed [DATA_W-1:0] a_val;
    logic                     a_bad;
    logic signed [DATA_W-1:0] u_diag;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic [25:0]              s_shift, s_trial;
    logic [32:0]              d_shift;
    logic signed [32:0]       q_val;
    logic signed [DATA_W-1:0] h_val;
    logic [SIZE_W-1:0]        n_start;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Active size clamps to [2, MAX_SIZE]
    always_comb
    begin
        if (size_reg < SIZE_W'(2))
        begin
            n_start = SIZE_W'(2);
        end
        else if (size_reg > SIZE_W'(MAX_SIZE))
        begin
            n_start = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            n_start = size_reg;
        end
    end

    assign n_minus  = n_reg - SIZE_W'(1);
    assign last_idx = n_minus[IDX_W-1:0];
    assign col_end  = last_idx - IDX_W'(1);
    assign j_last   = (j_reg == last_idx);
    assign k_last   = (k_reg == last_idx);
    assign m_last   = (m_reg == last_idx);
    assign col_last = (i_reg == col_end);

    // Floor shift of the registered product; squares are never negative.
    assign prod_sh  = prod_reg >>> 16;
    assign sig2_sum = {18'd0, sig2_reg} + {1'b0, prod_sh[47:0]};
    assign sig2_upd = (sig2_sum > 49'h7FFFFFFF) ? 31'h7FFFFFFF : sig2_sum[30:0];

    // Signed norm takes the sign of the diagonal entry
    assign sig    = rii_reg[DATA_W-1] ? -$signed({8'd0, root_reg}) : $signed({8'd0, root_reg});
    assign a_val  = sat32(64'($signed({1'b0, sig2_reg})) + 64'(sat32(prod_sh)));
    assign a_bad  = a_val[DATA_W-1] || (a_val == '0);
    assign u_diag = sat32(64'(rii_reg) + 64'(sig));

    // One restoring square-root step: two radicand bits a cycle
    assign s_shift = {srem_reg[23:0], sv_reg[47:46]};
    assign s_trial = {root_reg, 2'b01};

    // One restoring division step on magnitudes
    assign d_shift = {drem_reg[31:0], dq_reg[63]};

    // Truncated quotient saturated to 32 bits, then H = delta - q saturated
    always_comb
    begin
        if (!dneg_reg)
        begin
            q_val = (dq_reg > 64'h7FFFFFFF) ? 33'sh07FFFFFFF : $signed({1'b0, dq_reg[31:0]});
        end
        else
        begin
            q_val = (dq_reg > 64'h80000000) ? -33'sh080000000
                                            : -$signed({1'b0, dq_reg[31:0]});
        end
    end

    assign h_val = sat32(((k_reg == j_reg) ? 64'(ONE_Q16) : 64'sd0) - 64'(q_val));

    // One shared 32x32 multiplier, registered
    always_comb
    begin
        unique case (state_reg)
            S_NMUL:
            begin
                mul_a = $signed(ma_rdata);
                mul_b = $signed(ma_rdata);
            end
            S_AMUL:
            begin
                mul_a = rii_reg;
                mul_b = sig;
            end
            S_HMUL:
            begin
                mul_a = uk_reg;
                mul_b = u_reg[j_reg];
            end
            S_PMUL:
            begin
                mul_a = $signed(mb_rdata);
                mul_b = $signed(ma_rdata);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_item.is_last)
                begin
                    state_next = S_QINIT;
                end
            end
            S_QINIT:
            begin
                if (k_last && j_last)
                begin
                    state_next = S_NRD;
                end
            end
            S_NRD:  state_next = S_NMUL;
            S_NMUL: state_next = S_NACC;
            S_NACC:
            begin
                if (!j_last)
                begin
                    state_next = S_NRD;
                end
                else if (sig2_upd != '0)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = col_last ? S_ERD : S_NRD;
                end
            end
            S_SQRT:
            begin
                if (scnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = S_AMUL;
                end
            end
            S_AMUL: state_next = S_AADD;
            S_AADD:
            begin
                if (!a_bad)
                begin
                    state_next = S_HROW;
                end
                else
                begin
                    state_next = col_last ? S_ERD : S_NRD;
                end
            end
            S_HROW: state_next = S_HMUL;
            S_HMUL: state_next = S_HLD;
            S_HLD:  state_next = S_HDIV;
            S_HDIV:
            begin
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = S_HWR;
                end
            end
            S_HWR:
            begin
                priority if (j_last && k_last)
                begin
                    state_next = S_PRD;
                end
                else if (j_last)
                begin
                    state_next = S_HROW;
                end
                else
                begin
                    state_next = S_HMUL;
                end
            end
            S_PRD:  state_next = S_PMUL;
            S_PMUL: state_next = S_PACC;
            S_PACC: state_next = m_last ? S_PWR : S_PRD;
            S_PWR:  state_next = (j_last && k_last) ? S_CRD : S_PRD;
            S_CRD:  state_next = S_CWR;
            S_CWR:
            begin
                priority if (!(j_last && k_last))
                begin
                    state_next = S_CRD;
                end
                else if (tgt_reg == MAT_QT)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = col_last ? S_ERD : S_NRD;
                end
            end
            S_ERD:
            begin
                if (out_free)
                begin
                    state_next = S_ELD;
                end
            end
            S_ELD:
            begin
                if (tgt_reg == MAT_R && k_last && j_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ERD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, memory ports and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        tgt_next       = tgt_reg;
        sig2_next      = sig2_reg;
        rii_next       = rii_reg;
        u_next         = u_reg;
        uk_next        = uk_reg;
        a_next         = a_reg;
        acc_next       = acc_reg;
        sv_next        = sv_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        scnt_next      = scnt_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        dcnt_next      = dcnt_reg;
        dneg_next      = dneg_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;

        ma_we    = 1'b0;
        ma_waddr = {tgt_reg, k_reg, j_reg};
        ma_wdata = '0;
        ma_raddr = {MAT_R, j_reg, i_reg};
        mb_we    = 1'b0;
        mb_waddr = {1'b0, k_reg, j_reg};
        mb_wdata = h_val;
        mb_raddr = {1'b1, k_reg, j_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                // Store the element into R; start on the last one
                if (in_acc)
                begin
                    ma_we    = 1'b1;
                    ma_waddr = {MAT_R, in_item.row_index, in_item.column_index};
                    ma_wdata = in_item.element_value;
                    if (in_item.is_last)
                    begin
                        n_next = n_start;
                        k_next = '0;
                        j_next = '0;
                    end
                end
            end
            S_QINIT:
            begin
                ma_we    = 1'b1;
                ma_waddr = {MAT_QT, k_reg, j_reg};
                ma_wdata = (k_reg == j_reg) ? ONE_Q16 : '0;
                j_next   = j_last ? '0 : j_reg + IDX_W'(1);
                if (j_last)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                if (j_last && k_last)
                begin
                    i_next    = '0;
                    j_next    = '0;
                    sig2_next = '0;
                end
            end
            S_NRD:
            begin
                ma_raddr = {MAT_R, j_reg, i_reg};
            end
            S_NMUL:
            begin
                // Grab the column entry for the reflector and the diagonal
                u_next[j_reg] = $signed(ma_rdata);
                if (j_reg == i_reg)
                begin
                    rii_next = $signed(ma_rdata);
                end
            end
            S_NACC:
            begin
                sig2_next = sig2_upd;
                j_next    = j_reg + IDX_W'(1);
                if (j_last)
                begin
                    sv_next   = {1'b0, sig2_upd, 16'd0};
                    root_next = '0;
                    srem_next = '0;
                    scnt_next = '0;
                    if (sig2_upd == '0)
                    begin
                        i_next    = i_reg + IDX_W'(1);
                        j_next    = i_reg + IDX_W'(1);
                        sig2_next = '0;
                        tgt_next  = MAT_QT;
                        k_next    = '0;
                        if (col_last)
                        begin
                            j_next = '0;
                        end
                    end
                end
            end
            S_SQRT:
            begin
                sv_next   = {sv_reg[45:0], 2'b00};
                scnt_next = scnt_reg + 5'd1;
                if (s_shift >= s_trial)
                begin
                    srem_next = s_shift - s_trial;
                    root_next = {root_reg[22:0], 1'b1};
                end
                else
                begin
                    srem_next = s_shift;
                    root_next = {root_reg[22:0], 1'b0};
                end
            end
            S_AMUL:
            begin
                // product rii * sig lands in prod_reg
            end
            S_AADD:
            begin
                a_next = a_val;
                for (int e = 0; e < MAX_SIZE; e++)
                begin
                    if (IDX_W'(e) < i_reg)
                    begin
                        u_next[e] = '0;
                    end
                    else if (IDX_W'(e) == i_reg)
                    begin
                        u_next[e] = u_diag;
                    end
                end
                k_next = '0;
                j_next = '0;
                if (a_bad)
                begin
                    i_next    = i_reg + IDX_W'(1);
                    j_next    = col_last ? '0 : i_reg + IDX_W'(1);
                    sig2_next = '0;
                    tgt_next  = MAT_QT;
                end
            end
            S_HROW:
            begin
                uk_next = u_reg[k_reg];
            end
            S_HMUL:
            begin
                // u[k] * u[j] lands in prod_reg
            end
            S_HLD:
            begin
                dneg_next = prod_reg[63];
                dq_next   = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
                drem_next = '0;
                dcnt_next = '0;
            end
            S_HDIV:
            begin
                dcnt_next = dcnt_reg + 6'd1;
                if (d_shift >= {1'b0, a_reg})
                begin
                    drem_next = d_shift - {1'b0, a_reg};
                    dq_next   = {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_next = d_shift;
                    dq_next   = {dq_reg[62:0], 1'b0};
                end
            end
            S_HWR:
            begin
                mb_we    = 1'b1;
                mb_waddr = {1'b0, k_reg, j_reg};
                mb_wdata = h_val;
                j_next   = j_last ? '0 : j_reg + IDX_W'(1);
                if (j_last)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                if (j_last && k_last)
                begin
                    k_next   = '0;
                    m_next   = '0;
                    tgt_next = MAT_QT;
                    acc_next = '0;
                end
            end
            S_PRD:
            begin
                mb_raddr = {1'b0, k_reg, m_reg};
                ma_raddr = {tgt_reg, m_reg, j_reg};
            end
            S_PMUL:
            begin
                // H[k][m] * X[m][j] lands in prod_reg
            end
            S_PACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_sh);
                m_next   = m_reg + IDX_W'(1);
            end
            S_PWR:
            begin
                mb_we    = 1'b1;
                mb_waddr = {1'b1, k_reg, j_reg};
                mb_wdata = sat32(64'(acc_reg));
                acc_next = '0;
                m_next   = '0;
                j_next   = j_last ? '0 : j_reg + IDX_W'(1);
                if (j_last)
                begin
                    k_next = k_last ? '0 : k_reg + IDX_W'(1);
                end
            end
            S_CRD:
            begin
                mb_raddr = {1'b1, k_reg, j_reg};
            end
            S_CWR:
            begin
                ma_we    = 1'b1;
                ma_waddr = {tgt_reg, k_reg, j_reg};
                ma_wdata = mb_rdata;
                j_next   = j_last ? '0 : j_reg + IDX_W'(1);
                if (j_last)
                begin
                    k_next = k_last ? '0 : k_reg + IDX_W'(1);
                end
                if (j_last && k_last)
                begin
                    if (tgt_reg == MAT_QT)
                    begin
                        tgt_next = MAT_R;
                        m_next   = '0;
                        acc_next = '0;
                    end
                    else
                    begin
                        // Advance to the next column, or set up emission
                        tgt_next  = MAT_QT;
                        i_next    = i_reg + IDX_W'(1);
                        j_next    = col_last ? '0 : i_reg + IDX_W'(1);
                        sig2_next = '0;
                    end
                end
            end
            S_ERD:
            begin
                ma_raddr = {tgt_reg, k_reg, j_reg};
            end
            S_ELD:
            begin
                out_valid_next             = 1'b1;
                out_item_next.which_matrix = tgt_reg;
                out_item_next.out_row      = k_reg;
                out_item_next.out_column   = j_reg;
                out_item_next.out_value    = $signed(ma_rdata);
                out_item_next.last_result  = (tgt_reg == MAT_R) && k_last && j_last;
                j_next = j_last ? '0 : j_reg + IDX_W'(1);
                if (j_last)
                begin
                    k_next = k_last ? '0 : k_reg + IDX_W'(1);
                    if (k_last)
                    begin
                        tgt_next = MAT_R;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Emission entry from a column exit sets k to zero; handled since k
    // wraps to zero at the end of every sweep.

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_W'(4);
            n_reg         <= SIZE_W'(MAX_SIZE);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            tgt_reg       <= MAT_QT;
            scnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_enable)
            begin
                size_reg <= cfg_write_data;
            end
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            tgt_reg       <= tgt_next;
            scnt_reg      <= scnt_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig2_reg     <= sig2_next;
        rii_reg      <= rii_next;
        u_reg        <= u_next;
        uk_reg       <= uk_next;
        a_reg        <= a_next;
        prod_reg     <= 64'(mul_a) * 64'(mul_b);
        acc_reg      <= acc_next;
        sv_reg       <= sv_next;
        root_reg     <= root_next;
        srem_reg     <= srem_next;
        dq_reg       <= dq_next;
        drem_reg     <= drem_next;
        dneg_reg     <= dneg_next;
        out_item_reg <= out_item_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HQR_ASSERT_IMP(a_result_from_load, $rose(out_valid_reg), $past(state_reg) == S_ELD,
        "result valid rose outside the emit load")
    `HQR_ASSERT_IMP(a_no_overwrite, state_reg == S_ELD, !out_valid_reg,
        "pending result overwritten")
    `HQR_ASSERT_IMP(a_divisor_positive, state_reg == S_HDIV, !a_reg[DATA_W-1] && (a_reg != '0),
        "reflector divisor not positive")
    `HQR_ASSERT_NXT(a_sqrt_bounded, state_reg == S_SQRT && scnt_reg == 5'(SQRT_STEPS - 1),
        state_reg == S_AMUL, "square root ran past its step count")

endmodule

/* hdl/hqr_ram.sv */
// ----------------------------------------------------------------------------
// hqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Householder QR decomposer testbench
// Loads square Q15.16 matrices over several matrix sizes and predicts every
// emitted Q-transpose and R element in the testbench. Each emitted element is
// checked field by field, in order, against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hqr_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_GOAL   = 150;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_write_enable = 1'b0;
    logic [SIZE_W-1:0] cfg_write_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    hqr_in_t  in_item = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    hqr_out_t out_item;

    householder_qr_decomposer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_item         (out_item)
    );

    always #5 clk = ~clk;

    // Elements waiting to be driven, and decomposer outputs still owed.
    hqr_in_t  element_q[$];
    hqr_out_t owed_q[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       idle_mode = 0;   // 0: sender idles 30%, receiver 49%; 1: swapped; 2: none
    logic     in_fire = 1'b0;

    // Shadow of the decomposer contents.
    logic [SIZE_W-1:0] size_reg = 3'd4;
    int r_mat[MAX_SIZE][MAX_SIZE];
    int qt_mat[MAX_SIZE][MAX_SIZE];
    int refl[MAX_SIZE];

    // Generator bookkeeping: which store entries have ever been loaded.
    bit loaded[MAX_SIZE][MAX_SIZE];
    int gen_size = 4;
    int generated = 0;

    function automatic int sat_q(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    // Q15.16 product, floor rounded.
    function automatic longint mul_fx(int x, int y);
        longint p;
        p = longint'(x) * longint'(y);
        return p >>> 16;
    endfunction

    function automatic longint root24(longint v);
        longint root, t;
        root = 0;
        for (int b = 23; b >= 0; b--)
        begin
            t = root | (64'sd1 << b);
            if (t * t <= v)
                root = t;
        end
        return root;
    endfunction

    function automatic int eff_size();
        if (size_reg < 2)
            return 2;
        if (size_reg > MAX_SIZE)
            return MAX_SIZE;
        return int'(size_reg);
    endfunction

    // Multiply x by the reflector h in place (x := h x) over the n x n corner.
    task automatic reflect(input int h[MAX_SIZE][MAX_SIZE], inout int x[MAX_SIZE][MAX_SIZE],
                           input int n);
        int w[MAX_SIZE][MAX_SIZE];
        longint acc;
        for (int k = 0; k < n; k++)
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int m = 0; m < n; m++)
                    acc += mul_fx(h[k][m], x[m][j]);
                w[k][j] = sat_q(acc);
            end
        for (int k = 0; k < n; k++)
            for (int j = 0; j < n; j++)
                x[k][j] = w[k][j];
    endtask

    // Store one element; on the final one, run the QR and queue all results.
    task automatic predict_qr(input hqr_in_t it);
        int n, temp, sig, a, rii;
        longint sig2, p, dg;
        int h[MAX_SIZE][MAX_SIZE];
        hqr_out_t o;
        r_mat[it.row_index][it.column_index] = it.element_value;
        if (!it.is_last)
            return;
        n = eff_size();
        for (int k = 0; k < n; k++)
            for (int j = 0; j < n; j++)
                qt_mat[k][j] = (k == j) ? 32'sd65536 : 0;
        for (int i = 0; i + 1 < n; i++)
        begin
            sig2 = 0;
            for (int j = i; j < n; j++)
            begin
                sig2 += mul_fx(r_mat[j][i], r_mat[j][i]);
                if (sig2 > 64'sd2147483647)
                    sig2 = 64'sd2147483647;
            end
            // Skip a zero-norm column: nothing to reflect.
            if (sig2 == 0)
                continue;
            temp = int'(root24(sig2 <<< 16));
            rii = r_mat[i][i];
            sig = (rii < 0) ? -temp : temp;
            a = sat_q(sig2 + longint'(sat_q(mul_fx(rii, sig))));
            if (a <= 0)
                continue;
            for (int j = 0; j < n; j++)
                refl[j] = (j < i) ? 0 : (j == i) ? sat_q(longint'(rii) + sig) : r_mat[j][i];
            for (int k = 0; k < n; k++)
                for (int j = 0; j < n; j++)
                begin
                    p = longint'(refl[k]) * longint'(refl[j]);
                    dg = (k == j) ? 64'sd65536 : 64'sd0;
                    h[k][j] = sat_q(dg - longint'(sat_q(p / longint'(a))));
                end
            reflect(h, qt_mat, n);
            reflect(h, r_mat, n);
        end
        for (int mt = 0; mt < 2; mt++)
            for (int k = 0; k < n; k++)
                for (int j = 0; j < n; j++)
                begin
                    o.which_matrix = (mt == 1) ? MAT_R : MAT_QT;
                    o.out_row      = idx_t'(k);
                    o.out_column   = idx_t'(j);
                    o.out_value    = (mt == 1) ? r_mat[k][j] : qt_mat[k][j];
                    o.last_result  = (mt == 1 && k == n - 1 && j == n - 1);
                    owed_q.push_back(o);
                end
    endtask

    // Element values by flavor: 0 random, 1 small, 2 zero, 3 extremes,
    // 4 small with column 0 zeroed (zero-norm first column).
    function automatic int pick_value(int flavor, int c);
        int ext[5] = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1};
        case (flavor)
            0: return int'($urandom);
            1: return int'($urandom_range(0, 32'h60000)) - 32'sh30000;
            2: return 0;
            3: return ext[$urandom_range(0, 4)];
            default: return (c == 0) ? 0 : int'($urandom_range(0, 32'h60000)) - 32'sh30000;
        endcase
    endfunction

    task automatic push_element(int r, int c, int v, bit last);
        hqr_in_t it;
        it.row_index     = idx_t'(r);
        it.column_index  = idx_t'(c);
        it.element_value = v;
        it.is_last       = last;
        element_q.push_back(it);
        loaded[r][c] = 1'b1;
        generated++;
    endtask

    // Load the whole active corner in shuffled order, final element starts the run.
    // Sprinkle in elements outside the corner, which are stored but unused.
    task automatic load_matrix(int flavor);
        int pos[$];
        for (int i = 0; i < gen_size * gen_size; i++)
            pos.push_back(i);
        pos.shuffle();
        foreach (pos[i])
        begin
            if (gen_size < MAX_SIZE && $urandom_range(0, 5) == 0)
                push_element($urandom_range(gen_size, 3), $urandom_range(0, 3),
                             int'($urandom), 1'b0);
            push_element(pos[i] / gen_size, pos[i] % gen_size,
                         pick_value(flavor, pos[i] % gen_size), i == pos.size() - 1);
        end
    endtask

    // Update a few entries anywhere, restart on old contents; full load if unloaded.
    task automatic touch_matrix();
        bit ready = 1'b1;
        for (int r = 0; r < gen_size; r++)
            for (int c = 0; c < gen_size; c++)
                ready &= loaded[r][c];
        if (!ready)
        begin
            load_matrix(1);
            return;
        end
        repeat ($urandom_range(0, 3))
            push_element($urandom_range(0, 3), $urandom_range(0, 3),
                         pick_value($urandom_range(0, 3), 1), 1'b0);
        push_element($urandom_range(0, gen_size - 1), $urandom_range(0, gen_size - 1),
                     pick_value(1, 1), 1'b1);
    endtask

    // Wait until every element went in and every result came out, then settle.
    task automatic drain();
        while (element_q.size() != 0 || in_valid || owed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write matrix_size while the decomposer is idle.
    task automatic set_size(logic [SIZE_W-1:0] v);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= v;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        gen_size = (v < 2) ? 2 : (v > MAX_SIZE) ? MAX_SIZE : int'(v);
    endtask

    // Accept side: note transactions and config writes, feed the predictor.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cfg_write_enable)
            size_reg = cfg_write_data;
        in_fire <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            predict_qr(in_item);
    end

    // Driver: advance to the next element after a transaction, or hold.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (element_q.size() != 0 &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 30) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 49))
            begin
                in_valid <= 1'b1;
                in_item  <= element_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= (idle_mode == 0 && $urandom_range(0, 99) < 49) ||
                     (idle_mode == 1 && $urandom_range(0, 99) < 30);
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        hqr_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_q.size() == 0)
            begin
                $error("unexpected result %p", out_item);
                mismatches++;
            end
            else
            begin
                want = owed_q.pop_front();
                if (out_item.which_matrix !== want.which_matrix)
                begin
                    $error("which_matrix: expected %0d, got %0d",
                           want.which_matrix, out_item.which_matrix);
                    mismatches++;
                end
                if (out_item.out_row !== want.out_row)
                begin
                    $error("out_row: expected %0d, got %0d", want.out_row, out_item.out_row);
                    mismatches++;
                end
                if (out_item.out_column !== want.out_column)
                begin
                    $error("out_column: expected %0d, got %0d",
                           want.out_column, out_item.out_column);
                    mismatches++;
                end
                if (out_item.out_value !== want.out_value)
                begin
                    $error("out_value: expected %0d, got %0d",
                           want.out_value, out_item.out_value);
                    mismatches++;
                end
                if (out_item.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, out_item.last_result);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the decomposer hangs.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [SIZE_W-1:0] sizes[8] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd5, 3'd1, 3'd4, 3'd2};
        int phase;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: small matrices covering every value flavor.
        set_size(3'd2);
        for (int f = 0; f < 5; f++)
            load_matrix(f);
        drain();
        set_size(3'd4);
        load_matrix(3);
        drain();

        // Random: step through sizes, mostly full loads, some partial updates.
        phase = 0;
        while (generated < ITEM_GOAL - 20)
        begin
            idle_mode = (generated < 70) ? 0 : (generated < 105) ? 1 : 2;
            set_size(sizes[phase % 8]);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 3) == 0)
                    touch_matrix();
                else
                    load_matrix($urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 4));
            end
            drain();
            phase++;
        end

        drain();
        if (mismatches == 0 && owed_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* householder_qr_decomposer.f */
+incdir+hdl
hdl/hqr_pkg.sv
hdl/hqr_ram.sv
hdl/householder_qr_decomposer.sv
dv/testbench.sv
